[design/scpd_pkg.sv]
// Shared types, constants and SHA-256 helpers for the checked package deframer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package scpd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [1:0] status;
   } rsp_type;

   localparam logic       KIND_DATA    = 1'b0;
   localparam logic       KIND_VERDICT = 1'b1;
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SHORT     = 2'd1;
   localparam logic [1:0] ST_MISMATCH  = 2'd2;

   typedef enum logic [2:0] {
      PH_HCOUNT, PH_HEADER, PH_LENGTH, PH_DATA,
      PH_FCOUNT, PH_FOOTER, PH_DIGEST, PH_DONE
   } phase_type;

   // Work item handed from the parser to the hash engine, one per request.
   typedef struct packed {
      logic [7:0] value;
      logic       hash;     // feed value into SHA-256
      logic       emit;     // pass value out as a data byte
      logic       finish;   // pad and close the hash after this byte
      logic       cmp;      // compare value with the next digest byte
      logic       verdict;  // package ends here
      logic       done;     // whole digest has been received
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_ROUND, BK_ADD, BK_PAD_MARK, BK_PAD_ZERO, BK_PAD_LEN
   } back_type;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

[design/sha256_checked_package_deframer_unit.sv]
// Top level of the SHA-256 checked package deframer.
// Depends on scpd_pkg, scpd_front, scpd_queue and scpd_back.
`timescale 1ns / 1ps

// Takes a decrypted package one byte per request: header count and header
// bytes, a 32-bit big-endian data length, the data bytes, footer count and
// footer bytes, then the 32-byte SHA-256 digest of everything before it.
// Each data byte is returned as a kind-0 response as soon as it is hashed;
// the request marked last_byte yields one kind-1 verdict (ok, too short or
// digest mismatch) and readies the block for the next package. Bytes after
// the digest are ignored. Downstream must drop the data bytes unless the
// verdict is ok. A request is taken whenever the work queue has room; the
// hash engine then takes each byte while the response register is free and
// it is idle, and after every completed 64-byte block it runs 64 rounds of
// a single shared round unit and one add-back. After the footer it pads
// with 0x80, zero bytes and the 64-bit length, and compresses each of the
// one or two blocks that the padding closes. Sustained throughput is
// therefore set by the round unit.

module sha256_checked_package_deframer_unit #(
   parameter int QUEUE_DEPTH = scpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scpd_pkg::rsp_type rsp_data
);
   import scpd_pkg::*;

   logic    accept;
   logic    q_full, q_empty, q_pop;
   cmd_type front_cmd, back_cmd;

   // front side only needs queue room
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   scpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   scpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (back_cmd),
      .empty     (q_empty)
   );

   scpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (back_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[design/scpd_front.sv]
// Section parser: tracks the package layout and turns each request into a work item.
// Depends on scpd_pkg.
`timescale 1ns / 1ps

module scpd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  scpd_pkg::req_type req_data,
   output scpd_pkg::cmd_type cmd
);
   import scpd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] len_ff, len_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [7:0]  b;
   logic [31:0] len_full;

   assign b        = req_data.byte_value;
   assign len_full = {len_ff[23:0], b};

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.value = b;
      unique case (phase_ff)
         PH_HCOUNT: begin
            cmd.hash  = 1'b1;
            remain_in = {24'b0, b};
            len_in    = '0;
            cnt_in    = '0;
            phase_in  = (b != 8'd0) ? PH_HEADER : PH_LENGTH;
         end
         PH_HEADER: begin
            cmd.hash  = 1'b1;
            remain_in = remain_ff - 32'd1;
            if (remain_ff == 32'd1) phase_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            cmd.hash = 1'b1;
            len_in   = len_full;
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in    = '0;
               remain_in = len_full;
               phase_in  = (len_full != 32'd0) ? PH_DATA : PH_FCOUNT;
            end
         end
         PH_DATA: begin
            cmd.hash  = 1'b1;
            cmd.emit  = !req_data.last_byte;
            remain_in = remain_ff - 32'd1;
            if (remain_ff == 32'd1) phase_in = PH_FCOUNT;
         end
         PH_FCOUNT: begin
            cmd.hash  = 1'b1;
            remain_in = {24'b0, b};
            if (b != 8'd0) begin
               phase_in = PH_FOOTER;
            end else begin
               cmd.finish = 1'b1;
               cnt_in     = '0;
               phase_in   = PH_DIGEST;
            end
         end
         PH_FOOTER: begin
            cmd.hash  = 1'b1;
            remain_in = remain_ff - 32'd1;
            if (remain_ff == 32'd1) begin
               cmd.finish = 1'b1;
               cnt_in     = '0;
               phase_in   = PH_DIGEST;
            end
         end
         PH_DIGEST: begin
            cmd.cmp = 1'b1;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) phase_in = PH_DONE;
         end
         PH_DONE: begin
         end
      endcase
      cmd.done    = (phase_in == PH_DONE);
      cmd.verdict = req_data.last_byte;
      if (req_data.last_byte) begin
         phase_in  = PH_HCOUNT;
         remain_in = '0;
         len_in    = '0;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HCOUNT;
         remain_ff <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[design/scpd_queue.sv]
// Small work-item queue between the parser and the hash engine.
// Depends on scpd_pkg.
`timescale 1ns / 1ps

module scpd_queue #(
   parameter int DEPTH = scpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scpd_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output scpd_pkg::cmd_type pop_data,
   output logic              empty
);
   import scpd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type         store_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;

   assign full     = (cnt_ff == FULL_CNT);
   assign empty    = (cnt_ff == '0);
   assign pop_data = store_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
         if (pop)  rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + CW'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - CW'(1);
      end
   end

endmodule

[design/scpd_back.sv]
// Hash engine: SHA-256 block fill, iterative compression, padding, digest compare
// and the result register. Depends on scpd_pkg.
`timescale 1ns / 1ps

module scpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  scpd_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scpd_pkg::rsp_type rsp_data
);
   import scpd_pkg::*;

   back_type    state_ff, state_in, ret_ff, ret_in;
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [23:0] acc_ff, acc_in;
   logic [63:0] count_ff, count_in;
   logic [63:0] total_ff, total_in;
   logic [5:0]  round_ff, round_in;
   logic [7:0]  mis_ff, mis_in;
   logic [4:0]  cidx_ff, cidx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        slot_free;
   logic [5:0]  off;
   logic        hash_en;
   logic [7:0]  hash_val;
   logic [31:0] dword;
   logic [7:0]  dbyte;
   logic [7:0]  mis_v;
   logic [31:0] t1, t2, w_new;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign off       = count_ff[8:3];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dword = h_ff[cidx_ff[4:2]];
   always_comb begin
      unique case (cidx_ff[1:0])
         2'd0: dbyte = dword[31:24];
         2'd1: dbyte = dword[23:16];
         2'd2: dbyte = dword[15:8];
         2'd3: dbyte = dword[7:0];
      endcase
   end

   assign mis_v = mis_ff | (cmd.cmp ? (cmd.value ^ dbyte) : 8'd0);

   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_K[round_ff] + w_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
               ^ (work_ff[1] & work_ff[2]));
   assign w_new = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      h_in         = h_ff;
      work_in      = work_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      round_in     = round_ff;
      mis_in       = mis_ff;
      cidx_in      = cidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      hash_en      = 1'b0;
      hash_val     = 8'd0;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               if (cmd.verdict) begin
                  // a cut-short package never needs its hash finished
                  rsp_valid_in     = 1'b1;
                  rsp_in.kind      = KIND_VERDICT;
                  rsp_in.data_byte = 8'd0;
                  rsp_in.status    = !cmd.done ? ST_SHORT
                                   : ((mis_v != 8'd0) ? ST_MISMATCH : ST_OK);
                  h_in     = H_INIT;
                  count_in = '0;
                  mis_in   = '0;
                  cidx_in  = '0;
               end else if (cmd.cmp) begin
                  mis_in  = mis_v;
                  cidx_in = cidx_ff + 5'd1;
               end else if (cmd.hash) begin
                  hash_en  = 1'b1;
                  hash_val = cmd.value;
                  if (cmd.emit) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.kind      = KIND_DATA;
                     rsp_in.data_byte = cmd.value;
                     rsp_in.status    = ST_OK;
                  end
                  if (cmd.finish) total_in = count_ff + 64'd8;
                  if (off == 6'd63) begin
                     state_in = BK_ROUND;
                     ret_in   = cmd.finish ? BK_PAD_MARK : BK_IDLE;
                  end else if (cmd.finish) begin
                     state_in = BK_PAD_MARK;
                  end
               end
            end
         end
         BK_ROUND: begin
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = w_new;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = BK_ADD;
         end
         BK_ADD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + work_ff[i];
            state_in = ret_ff;
         end
         BK_PAD_MARK: begin
            hash_en  = 1'b1;
            hash_val = 8'h80;
            state_in = BK_PAD_ZERO;
            if (off == 6'd63) begin
               state_in = BK_ROUND;
               ret_in   = BK_PAD_ZERO;
            end
         end
         BK_PAD_ZERO: begin
            if (off == 6'd56) begin
               state_in = BK_PAD_LEN;
            end else begin
               hash_en = 1'b1;
               if (off == 6'd63) begin
                  state_in = BK_ROUND;
                  ret_in   = BK_PAD_ZERO;
               end
            end
         end
         BK_PAD_LEN: begin
            // length goes out most significant byte first
            hash_en  = 1'b1;
            hash_val = total_ff[63:56];
            total_in = {total_ff[55:0], 8'd0};
            if (off == 6'd63) begin
               state_in = BK_ROUND;
               ret_in   = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      if (hash_en) begin
         acc_in   = {acc_ff[15:0], hash_val};
         count_in = count_ff + 64'd8;
         if (off[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = {acc_ff, hash_val};
         end
      end
      if (state_in == BK_ROUND && state_ff != BK_ROUND) begin
         work_in  = h_ff;
         round_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ret_ff       <= BK_IDLE;
         h_ff         <= H_INIT;
         count_ff     <= '0;
         round_ff     <= '0;
         mis_ff       <= '0;
         cidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         h_ff         <= h_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         mis_ff       <= mis_in;
         cidx_ff      <= cidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      w_ff     <= w_in;
      acc_ff   <= acc_in;
      total_ff <= total_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[design/scpd_checker.sv]
// Port-level checks for the deframer, attached by bind.
// Depends on scpd_pkg and sha256_checked_package_deframer_unit.
`timescale 1ns / 1ps

module scpd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input scpd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input scpd_pkg::rsp_type rsp_data
);
   import scpd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_VERDICT |->
         rsp_data.status == ST_OK || rsp_data.status == ST_SHORT
         || rsp_data.status == ST_MISMATCH)
      else $error("bad verdict code");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_DATA |-> rsp_data.status == ST_OK)
      else $error("data byte carries a status");

   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_VERDICT |-> rsp_data.data_byte == 8'd0)
      else $error("verdict carries a data byte");

endmodule

bind sha256_checked_package_deframer_unit scpd_checker u_scpd_checker (.*);
